@@ rtl/assert_macros.svh @@
// Assertion macros used by the RTL core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge outside reset.
`define ASSERT_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/ctda_pkg.sv @@
// Types and constants of the complex ternary dot-accumulate core.
`timescale 1ns / 1ps

package ctda_pkg;

   localparam int NUM_BRANCHES  = 4;
   localparam int NUM_LANES     = 4;
   localparam int NUM_SUMS      = 4;
   localparam int CODE_W        = 2;
   localparam int LANE_W        = 8;
   localparam int DELTA_W       = 10;  // four 8-bit values: -512..508
   localparam int RES_W         = 32;

   // Lane code bits
   localparam int CODE_POS_BIT  = 0;   // clear: negate the activation
   localparam int CODE_IMAG_BIT = 1;   // set: imaginary-phase sums

   // Sum index within a branch
   localparam int SUM_RR = 0;
   localparam int SUM_RI = 1;
   localparam int SUM_IR = 2;
   localparam int SUM_II = 3;

   typedef logic [1:0] branch_type;
   localparam branch_type LAST_BRANCH = 2'd3;

   typedef struct packed {
      logic [7:0]  u0_code;
      logic [7:0]  u1_code;
      logic [7:0]  w0_code;
      logic [7:0]  w1_code;
      logic [31:0] act_real_lanes;
      logic [31:0] act_imag_lanes;
      logic        start_req;
      logic        finish;
   } req_item_type;

   typedef struct packed {
      logic signed [DELTA_W-1:0] rr;
      logic signed [DELTA_W-1:0] ri;
      logic signed [DELTA_W-1:0] ir;
      logic signed [DELTA_W-1:0] ii;
   } deltas_type;

endpackage

@@ rtl/ctda_if.sv @@
// Request and response channel interfaces of the dot-accumulate core.
`timescale 1ns / 1ps

interface ctda_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  u0_code;
   logic [7:0]  u1_code;
   logic [7:0]  w0_code;
   logic [7:0]  w1_code;
   logic [31:0] act_real_lanes;
   logic [31:0] act_imag_lanes;
   logic        start_req;
   logic        finish;

   modport source (
      output valid, u0_code, u1_code, w0_code, w1_code,
             act_real_lanes, act_imag_lanes, start_req, finish,
      input  ready
   );
   modport sink (
      input  valid, u0_code, u1_code, w0_code, w1_code,
             act_real_lanes, act_imag_lanes, start_req, finish,
      output ready
   );
endinterface

interface ctda_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         branch;
   logic signed [31:0] real_by_real;
   logic signed [31:0] real_by_imag;
   logic signed [31:0] imag_by_real;
   logic signed [31:0] imag_by_imag;
   logic               final_res;

   modport source (
      output valid, branch, real_by_real, real_by_imag, imag_by_real,
             imag_by_imag, final_res,
      input  ready
   );
   modport sink (
      input  valid, branch, real_by_real, real_by_imag, imag_by_real,
             imag_by_imag, final_res,
      output ready
   );
endinterface

@@ rtl/complex_ternary_dot_accumulate_core.sv @@
// Complex two-bit sign/phase dot-product accumulator, top level.
//
//  channel    dir   content
//  req_chan   in    code bytes u0 u1 w0 w1, 4+4 activation lanes, start, finish
//  rsp_chan   out   branch, four 32-bit branch sums, final flag
//
// One transaction per cycle while no finish waits on the result buffer: an input
// register feeds the sixteen accumulator adders, which update from it as it advances.
// A finish copies all sums into a result buffer drained one branch per cycle
// while the response side is ready, so a finish takes four result transactions;
// back-to-back finishes stall requests until the buffer's last result is taken.
// Synchronous reset clears accumulators, branch index and the input and buffer valid flags.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module complex_ternary_dot_accumulate_core #(
   parameter int ACC_WIDTH = 32
) (
   input logic        clock,
   input logic        reset,
   ctda_req_if.sink   req_chan,
   ctda_rsp_if.source rsp_chan
);

   localparam int NB = ctda_pkg::NUM_BRANCHES;
   localparam int NS = ctda_pkg::NUM_SUMS;
   localparam int RW = ctda_pkg::RES_W;

   ctda_pkg::req_item_type item_ff, item_in;
   logic                   item_valid_ff, item_valid_in;
   logic                   req_accept, rsp_accept, snap_free, item_advance, snap_load;

   logic [ACC_WIDTH-1:0]   acc_ff [NB][NS];
   logic [ACC_WIDTH-1:0]   acc_in [NB][NS];
   logic signed [RW-1:0]   snap_ff [NB][NS];
   logic signed [RW-1:0]   snap_in [NB][NS];
   logic                   snap_valid_ff, snap_valid_in;
   ctda_pkg::branch_type   branch_ff, branch_in;

   ctda_pkg::deltas_type   deltas [NB];
   logic signed [ctda_pkg::DELTA_W-1:0] dval [NB][NS];
   logic [7:0]             codes [NB];

   assign codes[0] = item_ff.u0_code;
   assign codes[1] = item_ff.u1_code;
   assign codes[2] = item_ff.w0_code;
   assign codes[3] = item_ff.w1_code;

   for (genvar b = 0; b < NB; b++) begin : g_branch
      ctda_branch_deltas u_deltas (
         .code_byte      (codes[b]),
         .act_real_lanes (item_ff.act_real_lanes),
         .act_imag_lanes (item_ff.act_imag_lanes),
         .deltas         (deltas[b])
      );
      assign dval[b][ctda_pkg::SUM_RR] = deltas[b].rr;
      assign dval[b][ctda_pkg::SUM_RI] = deltas[b].ri;
      assign dval[b][ctda_pkg::SUM_IR] = deltas[b].ir;
      assign dval[b][ctda_pkg::SUM_II] = deltas[b].ii;
   end

   // Handshake and flow control
   assign rsp_accept   = rsp_chan.valid && rsp_chan.ready;
   assign snap_free    = !snap_valid_ff || (rsp_accept && branch_ff == ctda_pkg::LAST_BRANCH);
   assign item_advance = item_valid_ff && (!item_ff.finish || snap_free);
   assign snap_load    = item_advance && item_ff.finish;
   assign req_chan.ready = !item_valid_ff || item_advance;
   assign req_accept   = req_chan.valid && req_chan.ready;

   always_comb begin
      item_in       = item_ff;
      item_valid_in = item_valid_ff && !item_advance;
      if (req_accept) begin
         item_in = '{u0_code:        req_chan.u0_code,
                     u1_code:        req_chan.u1_code,
                     w0_code:        req_chan.w0_code,
                     w1_code:        req_chan.w1_code,
                     act_real_lanes: req_chan.act_real_lanes,
                     act_imag_lanes: req_chan.act_imag_lanes,
                     start_req:      req_chan.start_req,
                     finish:         req_chan.finish};
         item_valid_in = 1'b1;
      end
   end

   // Accumulate and snapshot
   always_comb begin
      for (int b = 0; b < NB; b++) begin
         for (int s = 0; s < NS; s++) begin
            if (item_advance) begin
               acc_in[b][s] = (item_ff.start_req ? '0 : acc_ff[b][s])
                              + ACC_WIDTH'(dval[b][s]);
            end else begin
               acc_in[b][s] = acc_ff[b][s];
            end
            snap_in[b][s] = snap_load ? RW'($signed(acc_in[b][s])) : snap_ff[b][s];
         end
      end
   end

   always_comb begin
      snap_valid_in = snap_valid_ff;
      branch_in     = branch_ff;
      priority if (snap_load) begin
         snap_valid_in = 1'b1;
         branch_in     = '0;
      end else if (rsp_accept) begin
         if (branch_ff == ctda_pkg::LAST_BRANCH) begin
            snap_valid_in = 1'b0;
         end
         branch_in = ctda_pkg::branch_type'(branch_ff + 2'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         snap_valid_ff <= 1'b0;
         branch_ff     <= '0;
         for (int b = 0; b < NB; b++) begin
            for (int s = 0; s < NS; s++) begin
               acc_ff[b][s] <= '0;
            end
         end
      end else begin
         item_valid_ff <= item_valid_in;
         snap_valid_ff <= snap_valid_in;
         branch_ff     <= branch_in;
         acc_ff        <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      snap_ff <= snap_in;
   end

   // Result channel
   assign rsp_chan.valid        = snap_valid_ff;
   assign rsp_chan.branch       = branch_ff;
   assign rsp_chan.real_by_real = snap_ff[branch_ff][ctda_pkg::SUM_RR];
   assign rsp_chan.real_by_imag = snap_ff[branch_ff][ctda_pkg::SUM_RI];
   assign rsp_chan.imag_by_real = snap_ff[branch_ff][ctda_pkg::SUM_IR];
   assign rsp_chan.imag_by_imag = snap_ff[branch_ff][ctda_pkg::SUM_II];
   assign rsp_chan.final_res    = (branch_ff == ctda_pkg::LAST_BRANCH);

   // Assertions
   `ASSERT_RST(a_drain_steps, clock, reset,
      (rsp_accept && branch_ff != ctda_pkg::LAST_BRANCH && !snap_load) |=>
      (snap_valid_ff && branch_ff == ctda_pkg::branch_type'($past(branch_ff) + 2'd1)),
      "result drain did not step to the next branch")
   `ASSERT_RST(a_finish_held, clock, reset,
      (item_valid_ff && item_ff.finish && !snap_free) |=> (item_valid_ff && item_ff.finish),
      "finishing transaction lost while result buffer busy")
   `ASSERT_RST(a_drain_ends, clock, reset,
      (rsp_accept && branch_ff == ctda_pkg::LAST_BRANCH && !snap_load) |=> !snap_valid_ff,
      "result buffer still valid after its last branch")
   `ASSERT_ALWAYS(a_reset_idle, clock,
      reset |=> (!snap_valid_ff && !item_valid_ff),
      "valid state survived reset")

endmodule

@@ rtl/ctda_branch_deltas.sv @@
// Per-branch lane decode: four signed increments for one transaction.
`timescale 1ns / 1ps

module ctda_branch_deltas (
   input  logic [7:0]           code_byte,
   input  logic [31:0]          act_real_lanes,
   input  logic [31:0]          act_imag_lanes,
   output ctda_pkg::deltas_type deltas
);

   localparam int DW = ctda_pkg::DELTA_W;
   localparam int LW = ctda_pkg::LANE_W;
   localparam int CW = ctda_pkg::CODE_W;

   logic [CW-1:0]        code;
   logic [LW-1:0]        xr, xi, vr, vi;
   logic signed [DW-1:0] er, ei;
   logic signed [DW-1:0] rr, ri, ir, ii;

   always_comb begin
      rr = '0;
      ri = '0;
      ir = '0;
      ii = '0;
      code = '0;
      xr = '0;
      xi = '0;
      vr = '0;
      vi = '0;
      er = '0;
      ei = '0;
      for (int p = 0; p < ctda_pkg::NUM_LANES; p++) begin
         code = code_byte[CW*p +: CW];
         xr   = act_real_lanes[LW*p +: LW];
         xi   = act_imag_lanes[LW*p +: LW];
         if (!code[ctda_pkg::CODE_POS_BIT]) begin
            // 8-bit wrap: -128 stays -128
            vr = LW'({LW{1'b0}} - xr);
            vi = LW'({LW{1'b0}} - xi);
         end else begin
            vr = xr;
            vi = xi;
         end
         er = DW'($signed(vr));
         ei = DW'($signed(vi));
         if (code[ctda_pkg::CODE_IMAG_BIT]) begin
            ir = ir + er;
            ii = ii + ei;
         end else begin
            rr = rr + er;
            ri = ri + ei;
         end
      end
      deltas = '{rr: rr, ri: ri, ir: ir, ii: ii};
   end

endmodule
